/* sv/cubic_bezier_point_and_length_unit_defines.svh */
// ----------------------------------------------------------------------------
// Cubic Bezier point and length unit: assertion macros
// Shared macros for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_POINT_AND_LENGTH_UNIT_DEFINES_SVH
`define CUBIC_BEZIER_POINT_AND_LENGTH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBPL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBPL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cbpl_pkg.sv */
// ----------------------------------------------------------------------------
// cbpl_pkg
// Types, codes and constants shared by the Bezier point and length unit.
// ----------------------------------------------------------------------------
package cbpl_pkg;

    localparam int COORD_W = 16;
    localparam int REG_W   = 3 * COORD_W;
    localparam int T_W     = 17;
    localparam int DIST_W  = 17;
    localparam int SQ_W    = 34;
    localparam int LEN_W   = 19;
    localparam int ACC_W   = 20;

    localparam logic [T_W-1:0]   T_ONE   = 17'h10000;
    localparam logic [ACC_W-1:0] LEN_MAX = 20'd524287;
    localparam logic [SQ_W-1:0]  SQRT_TOP_BIT = 34'h1_0000_0000;

    // Operation codes of the input transaction.
    localparam logic [1:0] OP_POINT   = 2'd0;
    localparam logic [1:0] OP_SAMPLED = 2'd1;
    localparam logic [1:0] OP_FAST    = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_CTRL1  = 2'd1;
    localparam logic [1:0] REG_CTRL2  = 2'd2;
    localparam logic [1:0] REG_END    = 2'd3;

    // Point pair that feeds the distance unit.
    typedef enum logic [2:0] {
        DS_CUR,
        DS_CHORD,
        DS_NET01,
        DS_NET12,
        DS_NET23
    } t_dsrc;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [16:0] param_t;
        logic [10:0] sample_count;
    } t_in;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic [18:0]        curve_length;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       load_w;
        logic       div_init;
        logic       div_step;
        logic       div_first;
        logic       t_step;
        logic       lerp_en;
        logic [1:0] lerp_idx;
        logic       save_prev;
        logic       sq_en;
        t_dsrc      dsrc;
        logic       sum_en;
        logic       sqrt_step;
        logic       acc_add;
        logic       acc_sat;
        logic       out_load;
        logic [1:0] res_op;
    } t_cmd;

    // Signed coordinate k of a packed control point.
    function automatic logic signed [COORD_W-1:0] coord_of(
        input logic [REG_W-1:0] pt,
        input int unsigned      k
    );
        coord_of = $signed(pt[k*COORD_W +: COORD_W]);
    endfunction

endpackage

/* sv/cbpl_ctrl.sv */
// ----------------------------------------------------------------------------
// cbpl_ctrl
// Sequencer for the Bezier unit: handshakes, step counters and datapath
// commands.
// ----------------------------------------------------------------------------
module cbpl_ctrl #(
    parameter int MAX_SAMPLES = 1024,
    parameter int CW          = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cbpl_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cbpl_pkg::t_cmd o_cmd,
    output logic [CW-1:0]  o_div_m
);
    import cbpl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_LERP,
        S_PRIME,
        S_SEG,
        S_SQ,
        S_SUM,
        S_SQRT,
        S_ACC,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [1:0]    r_op;
    logic [4:0]    r_cnt;
    logic [1:0]    r_pair;
    logic [CW-1:0] r_seg;
    logic [CW-1:0] r_m;
    logic          r_first;
    logic          r_out_valid;

    logic          accept;
    logic          out_free;
    logic [CW-1:0] n_m;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Segment count is the clamped sample count less one.
    always_comb begin
        if (32'(i_in_data.sample_count) > MAX_SAMPLES) begin
            n_m = CW'(MAX_SAMPLES - 1);
        end else begin
            n_m = CW'(i_in_data.sample_count - 11'd1);
        end
    end

    // Command decode from the current state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.dsrc     = DS_CUR;
        o_cmd.res_op   = r_op;
        o_cmd.acc_sat  = (r_op == OP_SAMPLED);
        case (r_state)
            S_IDLE: begin
                o_cmd.capture  = accept;
                o_cmd.load_w   = accept;
                o_cmd.div_init = accept;
            end
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_cnt == 5'd0);
            end
            S_LERP: begin
                o_cmd.lerp_en = 1'b1;
                if (r_cnt < 5'd3) begin
                    o_cmd.lerp_idx = r_cnt[1:0];
                end else if (r_cnt < 5'd5) begin
                    o_cmd.lerp_idx = 2'(r_cnt - 5'd3);
                end else begin
                    o_cmd.lerp_idx = 2'd0;
                end
            end
            S_PRIME: begin
                o_cmd.save_prev = 1'b1;
            end
            S_SEG: begin
                o_cmd.t_step = 1'b1;
                o_cmd.load_w = 1'b1;
            end
            S_SQ: begin
                o_cmd.sq_en = 1'b1;
                if (r_op == OP_FAST) begin
                    case (r_pair)
                        2'd0:    o_cmd.dsrc = DS_CHORD;
                        2'd1:    o_cmd.dsrc = DS_NET01;
                        2'd2:    o_cmd.dsrc = DS_NET12;
                        default: o_cmd.dsrc = DS_NET23;
                    endcase
                end
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
            end
            S_ACC: begin
                o_cmd.acc_add   = 1'b1;
                o_cmd.save_prev = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // State, counters and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_POINT;
            r_cnt       <= '0;
            r_pair      <= '0;
            r_seg       <= '0;
            r_m         <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A result taken while no new one is loaded leaves the register empty.
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_in_data.opcode;
                        r_cnt   <= '0;
                        r_pair  <= '0;
                        r_seg   <= CW'(1);
                        r_m     <= n_m;
                        r_first <= 1'b1;
                        case (i_in_data.opcode)
                            OP_POINT: r_state <= S_LERP;
                            OP_SAMPLED: begin
                                if (i_in_data.sample_count < 11'd2) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            OP_FAST:  r_state <= S_SQ;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_DIV: begin
                    if (r_cnt == 5'd16) begin
                        r_cnt   <= '0;
                        r_state <= S_LERP;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_LERP: begin
                    if (r_cnt == 5'd5) begin
                        r_cnt <= '0;
                        if (r_op == OP_POINT) begin
                            r_state <= S_DONE;
                        end else if (r_first) begin
                            r_state <= S_PRIME;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_PRIME: begin
                    r_first <= 1'b0;
                    r_state <= S_SEG;
                end
                S_SEG: begin
                    r_state <= S_LERP;
                end
                S_SQ: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_cnt == 5'd16) begin
                        r_cnt   <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_ACC: begin
                    if (r_op == OP_FAST) begin
                        if (r_pair == 2'd3) begin
                            r_state <= S_DONE;
                        end else begin
                            r_pair  <= r_pair + 2'd1;
                            r_state <= S_SQ;
                        end
                    end else if (r_seg == r_m) begin
                        r_state <= S_DONE;
                    end else begin
                        r_seg   <= r_seg + CW'(1);
                        r_state <= S_SEG;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_div_m     = r_m;

endmodule

/* sv/cbpl_dp.sv */
// ----------------------------------------------------------------------------
// cbpl_dp
// Datapath: control point registers, three coordinate lanes with one
// multiplier each, parameter stepping divider, square root and accumulator.
// ----------------------------------------------------------------------------
module cbpl_dp #(
    parameter int CW = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_addr,
    input  logic [cbpl_pkg::REG_W-1:0]   i_cfg_wdata,
    input  cbpl_pkg::t_in                i_in_data,
    input  cbpl_pkg::t_cmd               i_cmd,
    input  logic [CW-1:0]                i_div_m,
    output cbpl_pkg::t_out               o_out_data
);
    import cbpl_pkg::*;

    logic [REG_W-1:0]         r_cfg [4];
    logic signed [COORD_W-1:0] r_w    [3][4];
    logic signed [COORD_W-1:0] r_prev [3];
    logic [SQ_W-1:0]          r_sq   [3];
    logic [T_W-1:0]           r_t;
    logic [CW-1:0]            r_tfrac;
    logic [CW-1:0]            r_rem;
    logic [T_W-1:0]           r_q;
    logic [SQ_W-1:0]          r_x;
    logic [SQ_W-1:0]          r_root;
    logic [SQ_W-1:0]          r_bit;
    logic [ACC_W-1:0]         r_acc;
    t_out                     r_out;
    t_out                     n_out;

    logic signed [17:0]       mul_a  [3];
    logic signed [17:0]       mul_b  [3];
    logic signed [35:0]       prod   [3];
    logic signed [COORD_W-1:0] lerp_r [3];

    logic [CW:0]              div_rs;
    logic                     div_ge;
    logic [CW:0]              t_sum;
    logic                     t_ge;
    logic [SQ_W:0]            sq_trial;
    logic                     sq_ge;
    logic [ACC_W-1:0]         acc_sum;

    // Lane operands: a lerp difference times t, or a squared coordinate gap.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [COORD_W-1:0] pa;
            logic signed [COORD_W-1:0] pb;
            logic signed [COORD_W:0]   d;
            pa = r_prev[k];
            pb = r_w[k][0];
            case (i_cmd.dsrc)
                DS_CHORD: begin
                    pa = coord_of(r_cfg[REG_END], k);
                    pb = coord_of(r_cfg[REG_START], k);
                end
                DS_NET01: begin
                    pa = coord_of(r_cfg[REG_START], k);
                    pb = coord_of(r_cfg[REG_CTRL1], k);
                end
                DS_NET12: begin
                    pa = coord_of(r_cfg[REG_CTRL2], k);
                    pb = coord_of(r_cfg[REG_CTRL1], k);
                end
                DS_NET23: begin
                    pa = coord_of(r_cfg[REG_END], k);
                    pb = coord_of(r_cfg[REG_CTRL2], k);
                end
                default: begin
                end
            endcase
            if (i_cmd.sq_en) begin
                d        = 17'(pa) - 17'(pb);
                mul_a[k] = 18'(d);
                mul_b[k] = 18'(d);
            end else begin
                d        = 17'(r_w[k][2'(i_cmd.lerp_idx + 2'd1)])
                         - 17'(r_w[k][i_cmd.lerp_idx]);
                mul_a[k] = 18'(d);
                mul_b[k] = $signed({1'b0, r_t});
            end
            prod[k]   = mul_a[k] * mul_b[k];
            lerp_r[k] = r_w[k][i_cmd.lerp_idx] + COORD_W'(prod[k] >>> 16);
        end
    end

    // One quotient bit of 65536 / m per step.
    assign div_rs = {r_rem, i_cmd.div_first};
    assign div_ge = (div_rs >= {1'b0, i_div_m});

    // Parameter advance by quotient plus carried remainder.
    assign t_sum = {1'b0, r_tfrac} + {1'b0, r_rem};
    assign t_ge  = (t_sum >= {1'b0, i_div_m});

    // One root bit per step.
    assign sq_trial = {1'b0, r_root} + {1'b0, r_bit};
    assign sq_ge    = ({1'b0, r_x} >= sq_trial);

    assign acc_sum = r_acc + ACC_W'(r_root[DIST_W-1:0]);

    // Result value; unused fields read zero.
    always_comb begin
        n_out = '0;
        case (i_cmd.res_op)
            OP_POINT: begin
                n_out.point_x = r_w[0][0];
                n_out.point_y = r_w[1][0];
                n_out.point_z = r_w[2][0];
            end
            OP_SAMPLED: n_out.curve_length = r_acc[LEN_W-1:0];
            OP_FAST:    n_out.curve_length = LEN_W'(r_acc >> 1);
            default: begin
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) begin
                r_cfg[j] <= '0;
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            if (i_in_data.opcode == OP_POINT) begin
                r_t <= (i_in_data.param_t > T_ONE) ? T_ONE : i_in_data.param_t;
            end else begin
                r_t <= '0;
            end
            r_tfrac <= '0;
            r_acc   <= '0;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? CW'(div_rs - {1'b0, i_div_m}) : div_rs[CW-1:0];
            r_q   <= {r_q[T_W-2:0], div_ge};
        end
        if (i_cmd.t_step) begin
            r_tfrac <= t_ge ? CW'(t_sum - {1'b0, i_div_m}) : t_sum[CW-1:0];
            r_t     <= r_t + r_q + T_W'(t_ge);
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.load_w) begin
                for (int j = 0; j < 4; j++) begin
                    r_w[k][j] <= coord_of(r_cfg[j], k);
                end
            end else if (i_cmd.lerp_en) begin
                r_w[k][i_cmd.lerp_idx] <= lerp_r[k];
            end
            if (i_cmd.save_prev) begin
                r_prev[k] <= r_w[k][0];
            end
            if (i_cmd.sq_en) begin
                r_sq[k] <= prod[k][SQ_W-1:0];
            end
        end
        if (i_cmd.sum_en) begin
            r_x    <= r_sq[0] + r_sq[1] + r_sq[2];
            r_root <= '0;
            r_bit  <= SQRT_TOP_BIT;
        end
        if (i_cmd.sqrt_step) begin
            if (sq_ge) begin
                r_x    <= r_x - sq_trial[SQ_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.acc_add) begin
            if (i_cmd.acc_sat && (acc_sum > LEN_MAX)) begin
                r_acc <= LEN_MAX;
            end else begin
                r_acc <= acc_sum;
            end
        end
        // Result register.
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

/* sv/cubic_bezier_point_and_length_unit.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_point_and_length_unit
// Evaluates a 3D cubic Bezier curve, its sampled arc length, or a fast
// length estimate from four control point registers.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       input      i_in_valid/o_in_stall  i_in_data (t_in)
//  out      output     o_out_valid/i_out_stall o_out_data (t_out)
//  cfg      input      i_cfg_we              i_cfg_addr, i_cfg_wdata
//
// Point: six lerps on the per-lane multiplier. Fast estimate: 4 distances,
// each through the 17-step square root. Sampled length with n samples: n-1
// segment distances, after a 17-step divider for the parameter step. One
// transaction at a time; a result waiting in the output register does not
// block the next input. Reset is synchronous and clears the control points
// and the controller.
// ----------------------------------------------------------------------------
module cubic_bezier_point_and_length_unit #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  cbpl_pkg::t_in              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output cbpl_pkg::t_out             o_out_data,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [cbpl_pkg::REG_W-1:0] i_cfg_wdata
);
    import cbpl_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES);

    t_cmd          cmd;
    logic [CW-1:0] div_m;

    // Sequencer.
    cbpl_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .o_div_m     (div_m)
    );

    // Datapath.
    cbpl_dp #(
        .CW (CW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_div_m     (div_m),
        .o_out_data  (o_out_data)
    );

endmodule

/* sv/cbpl_chk.sv */
// ----------------------------------------------------------------------------
// cbpl_chk
// Port-level checks for the Bezier unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "cubic_bezier_point_and_length_unit_defines.svh"

module cbpl_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input cbpl_pkg::t_in              i_in_data,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input cbpl_pkg::t_out             o_out_data,
    input logic                       i_cfg_we,
    input logic [1:0]                 i_cfg_addr,
    input logic [cbpl_pkg::REG_W-1:0] i_cfg_wdata
);

    // A stalled result holds.
    `CBPL_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // An accepted transaction makes the unit busy.
    `CBPL_ASSERT_NXT(a_busy, i_in_valid && !o_in_stall, o_in_stall, "not busy after accept")

    // A length result carries no point.
    `CBPL_ASSERT_IMP(a_fields, o_out_valid && (o_out_data.curve_length != 19'd0), (o_out_data.point_x == 16'sd0) && (o_out_data.point_y == 16'sd0) && (o_out_data.point_z == 16'sd0), "point fields set on a length result")

    // A new result only comes out of a busy unit.
    `CBPL_ASSERT_IMP(a_origin, $rose(o_out_valid), $past(o_in_stall), "result without work")

endmodule

bind cubic_bezier_point_and_length_unit cbpl_chk u_chk (.*);

/* sim/cubic_bezier_point_and_length_unit_test.sv */
// ----------------------------------------------------------------------------
// Cubic Bezier point and length unit testbench
// Drives point, sampled-length and fast-estimate transactions through several
// control point settings and checks every result against a built-in predictor.
// ----------------------------------------------------------------------------
module cubic_bezier_point_and_length_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cbpl_pkg::*;

    localparam int  MAX_N       = 1024;
    localparam int  IDLE_PCT    = 24;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN_GAP   = 64;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    t_in            i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    t_out           o_out_data;
    logic           i_cfg_we;
    logic [1:0]     i_cfg_addr;
    logic [REG_W-1:0] i_cfg_wdata;

    cubic_bezier_point_and_length_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Predictor copy of the control points.
    logic [REG_W-1:0] ctrl_pts [4];

    t_in   pending_items [$];
    t_out  expected_results [$];
    int    error_count;
    longint cycle_count;
    bit    send_idle_en;
    bit    recv_idle_en;
    bit    recv_hold_req;
    int    recv_hold_left;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Fixed-point helpers for the predictor.
    function automatic longint coord_at(input logic [REG_W-1:0] pt, input int k);
        logic signed [15:0] c;
        c = pt[k*16 +: 16];
        return longint'(c);
    endfunction

    function automatic longint lerp_trunc(input longint a, input longint b, input longint t);
        longint p;
        p = (b - a) * t;
        if (p >= 0)
            return a + (p >>> 16);
        return a - ((-p + 65535) >>> 16);
    endfunction

    function automatic void curve_point(input longint t, output longint pt [3]);
        longint a, b, c, d, ab, bc, cd, abc, bcd;
        for (int k = 0; k < 3; k++) begin
            a = coord_at(ctrl_pts[0], k);
            b = coord_at(ctrl_pts[1], k);
            c = coord_at(ctrl_pts[2], k);
            d = coord_at(ctrl_pts[3], k);
            ab = lerp_trunc(a, b, t);
            bc = lerp_trunc(b, c, t);
            cd = lerp_trunc(c, d, t);
            abc = lerp_trunc(ab, bc, t);
            bcd = lerp_trunc(bc, cd, t);
            pt[k] = lerp_trunc(abc, bcd, t);
        end
    endfunction

    function automatic longint int_sqrt(input longint x);
        longint r, b;
        r = 0;
        b = longint'(1) <<< 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint distance(input longint a [3], input longint b [3]);
        longint s;
        s = 0;
        for (int k = 0; k < 3; k++) s += (a[k] - b[k]) * (a[k] - b[k]);
        return int_sqrt(s);
    endfunction

    function automatic longint arc_length(input int n);
        longint prev [3];
        longint cur [3];
        longint sum, t;
        if (n > MAX_N) n = MAX_N;
        if (n < 2) return 0;
        sum = 0;
        curve_point(0, prev);
        for (int i = 1; i < n; i++) begin
            t = (longint'(i) * 65536) / (n - 1);
            curve_point(t, cur);
            sum += distance(prev, cur);
            if (sum > 524287) sum = 524287;
            prev = cur;
        end
        return sum;
    endfunction

    function automatic longint quick_length();
        longint p [4][3];
        longint chord, net, v;
        for (int j = 0; j < 4; j++)
            for (int k = 0; k < 3; k++) p[j][k] = coord_at(ctrl_pts[j], k);
        chord = distance(p[3], p[0]);
        net = distance(p[0], p[1]) + distance(p[2], p[1]) + distance(p[3], p[2]);
        v = (chord + net) >>> 1;
        return (v > 524287) ? 524287 : v;
    endfunction

    function automatic t_out bezier_result(input t_in item);
        t_out   r;
        longint pt [3];
        longint t;
        r = '0;
        t = item.param_t;
        if (t > 65536) t = 65536;
        case (item.opcode)
            OP_POINT: begin
                curve_point(t, pt);
                r.point_x = pt[0][15:0];
                r.point_y = pt[1][15:0];
                r.point_z = pt[2][15:0];
            end
            OP_SAMPLED: r.curve_length = 19'(arc_length(item.sample_count));
            OP_FAST:    r.curve_length = 19'(quick_length());
            default:    r = '0;
        endcase
        return r;
    endfunction

    // Driver: offers queued items; predictions are made at acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(bezier_result(i_in_data));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() > 0 &&
                    !(send_idle_en && $urandom_range(99, 0) < IDLE_PCT)) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                    i_in_data  <= t_in'(30'($urandom));
                end
            end
        end
    end

    // Receiver stall, with an occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall    <= 1'b0;
            recv_hold_left <= 0;
        end else if (recv_hold_req && recv_hold_left == 0) begin
            recv_hold_left <= 600;
            i_out_stall    <= 1'b1;
        end else if (recv_hold_left > 1) begin
            recv_hold_left <= recv_hold_left - 1;
            i_out_stall    <= 1'b1;
        end else begin
            recv_hold_left <= 0;
            i_out_stall    <= recv_idle_en && ($urandom_range(99, 0) < IDLE_PCT);
        end
    end

    // Monitor: compares each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction %h", o_out_data);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out_data.point_x !== exp_r.point_x) begin
                    $error("point_x: expected %0d, got %0d", exp_r.point_x, o_out_data.point_x);
                    error_count++;
                end
                if (o_out_data.point_y !== exp_r.point_y) begin
                    $error("point_y: expected %0d, got %0d", exp_r.point_y, o_out_data.point_y);
                    error_count++;
                end
                if (o_out_data.point_z !== exp_r.point_z) begin
                    $error("point_z: expected %0d, got %0d", exp_r.point_z, o_out_data.point_z);
                    error_count++;
                end
                if (o_out_data.curve_length !== exp_r.curve_length) begin
                    $error("curve_length: expected %0d, got %0d",
                           exp_r.curve_length, o_out_data.curve_length);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_in make_item(input logic [1:0] op, input int t, input int n);
        t_in it;
        it.opcode       = op;
        it.param_t      = 17'(t);
        it.sample_count = 11'(n);
        return it;
    endfunction

    // Mostly small sample counts; a few large or out-of-range ones.
    function automatic t_in random_item();
        int sel;
        int n;
        sel = $urandom_range(99, 0);
        if (sel < 6)       n = $urandom_range(2047, 0);
        else if (sel < 10) n = $urandom_range(1024, 600);
        else               n = $urandom_range(40, 0);
        return make_item(2'($urandom_range(3, 0)),
                         (sel % 7 == 0) ? $urandom_range(131071, 0) : $urandom_range(65536, 0),
                         n);
    endfunction

    // Checked at the falling edge, when all driver updates have settled.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        ctrl_pts[idx] = val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic load_curve(input logic [REG_W-1:0] p0, input logic [REG_W-1:0] p1,
                              input logic [REG_W-1:0] p2, input logic [REG_W-1:0] p3);
        write_reg(REG_START, p0);
        write_reg(REG_CTRL1, p1);
        write_reg(REG_CTRL2, p2);
        write_reg(REG_END, p3);
    endtask

    function automatic logic [REG_W-1:0] rand_reg();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // Stimulus sequence.
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_START;
        i_cfg_wdata   = '0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_en  = 1'b0;
        recv_idle_en  = 1'b0;
        recv_hold_req = 1'b0;
        for (int j = 0; j < 4; j++) ctrl_pts[j] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all-zero curve from reset, then extreme corners.
        pending_items.push_back(make_item(OP_FAST, 0, 0));
        pending_items.push_back(make_item(OP_SAMPLED, 0, 5));
        wait_idle();
        load_curve({3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}});
        pending_items.push_back(make_item(OP_POINT, 0, 0));
        pending_items.push_back(make_item(OP_POINT, 65536, 0));
        pending_items.push_back(make_item(OP_POINT, 131071, 2047));
        pending_items.push_back(make_item(OP_POINT, 32768, 0));
        pending_items.push_back(make_item(OP_POINT, 1, 0));
        pending_items.push_back(make_item(OP_SAMPLED, 0, 0));
        pending_items.push_back(make_item(OP_SAMPLED, 0, 1));
        pending_items.push_back(make_item(OP_SAMPLED, 0, 2));
        pending_items.push_back(make_item(OP_SAMPLED, 0, 3));
        pending_items.push_back(make_item(OP_SAMPLED, 0, 1024));
        pending_items.push_back(make_item(OP_SAMPLED, 0, 2047));
        pending_items.push_back(make_item(OP_FAST, 65536, 0));
        pending_items.push_back(make_item(OP_NONE, 131071, 2047));
        pending_items.push_back(make_item(OP_NONE, 0, 0));
        wait_idle();
        load_curve({16'h7fff, 16'h8000, 16'h0001}, {16'hffff, 16'h0000, 16'h7fff},
                   {16'h8000, 16'h7fff, 16'hffff}, {16'h0000, 16'h8001, 16'h8000});
        write_reg(REG_END, 48'hffff_ffff_ffff);
        pending_items.push_back(make_item(OP_POINT, 21845, 1365));
        pending_items.push_back(make_item(OP_POINT, 43690, 682));
        pending_items.push_back(make_item(OP_FAST, 0, 0));
        pending_items.push_back(make_item(OP_SAMPLED, 0, 7));
        wait_idle();

        // Random phases: first no idling, then random idling on both sides.
        for (int phase = 0; phase < 6; phase++) begin
            load_curve(rand_reg(), rand_reg(), rand_reg(), rand_reg());
            send_idle_en = (phase != 0);
            recv_idle_en = (phase != 0);
            for (int i = 0; i < 45; i++) pending_items.push_back(random_item());
            if (phase == 2) begin
                // Long receiver hold-off while the sender keeps offering.
                recv_hold_req = 1'b1;
                @(posedge i_clk);
                @(negedge i_clk);
                recv_hold_req = 1'b0;
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* cubic_bezier_point_and_length_unit.f */
+incdir+sv
sv/cbpl_pkg.sv
sv/cbpl_ctrl.sv
sv/cbpl_dp.sv
sv/cubic_bezier_point_and_length_unit.sv
sv/cbpl_chk.sv
sim/cubic_bezier_point_and_length_unit_test.sv
